// ----- design/polynomial_evaluator_unit_assert.svh -----
// Assertion helpers for the polynomial evaluator.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef POLYNOMIAL_EVALUATOR_UNIT_ASSERT_SVH
`define POLYNOMIAL_EVALUATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define PEVAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PEVAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PEVAL_ASSERT_SAME(lbl, ante, cons, msg)
`define PEVAL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/peval_pkg.sv -----
package peval_pkg;

  localparam int DATA_W            = 32;
  localparam int FRAC_W            = 16;
  localparam int TC_W              = 3;
  localparam int IDX_W             = 3;
  localparam int DEFAULT_MAX_TERMS = 7;

  // register indexes on the config port
  localparam logic [IDX_W-1:0] CFG_TERM_COUNT = 3'd7;

  localparam logic [TC_W-1:0] TERM_COUNT_RESET = 3'd1;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } peval_state_e;

  // sequencer -> datapath controls
  typedef struct packed {
    logic take;   // latch x, clear acc and flag
    logic load;   // acc <= top coefficient
    logic mul;    // product register <= acc * x
    logic add;    // acc <= sat(sat(prod >>> 16) + coeff)
    logic done;   // result moves to output register
  } peval_ctl_t;

endpackage

// ----- design/peval_cfg.sv -----
module peval_cfg
  import peval_pkg::*;
#(
  parameter int MAX_TERMS = DEFAULT_MAX_TERMS,
  parameter int KW        = 3,
  parameter int NW        = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic [KW-1:0]            k_i,
  output logic signed [DATA_W-1:0] coeff_o,
  output logic [NW-1:0]            n_o
);

  logic signed [DATA_W-1:0] coeff_q [MAX_TERMS];
  logic [TC_W-1:0]          tc_q;
  logic [TC_W-1:0]          tc_clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        coeff_q[i] <= '0;
      end
      tc_q <= TERM_COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TERM_COUNT) begin
        tc_q <= cfg_data_i[TC_W-1:0];
      end else if (cfg_idx_i < IDX_W'(MAX_TERMS)) begin
        coeff_q[cfg_idx_i[KW-1:0]] <= cfg_data_i;
      end
    end
  end

  // counts above the built depth use the full depth
  assign tc_clip = (tc_q > TC_W'(MAX_TERMS)) ? TC_W'(MAX_TERMS) : tc_q;
  assign n_o     = NW'(tc_clip);
  assign coeff_o = coeff_q[k_i];

endmodule

// ----- design/peval_mac.sv -----
module peval_mac
  import peval_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  peval_ctl_t               ctl_i,
  input  logic signed [DATA_W-1:0] point_i,
  input  logic signed [DATA_W-1:0] coeff_i,
  output logic signed [DATA_W-1:0] acc_o,
  output logic                     ovf_o
);

  localparam int PW = 2 * DATA_W;
  localparam int SW = PW - FRAC_W;

  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] acc_q, acc_d;
  logic signed [PW-1:0]     prod_q;
  logic                     ovf_q, ovf_d;

  logic [SW-1:0]            shifted;
  logic                     prod_ovf;
  logic signed [DATA_W-1:0] prod_sat;
  logic [DATA_W:0]          sum;
  logic                     sum_ovf;
  logic signed [DATA_W-1:0] sum_sat;

  // floor shift, then clip to 32 bits
  always_comb begin
    shifted  = prod_q[PW-1:FRAC_W];
    prod_ovf = !((&shifted[SW-1:DATA_W-1]) || !(|shifted[SW-1:DATA_W-1]));
    if (prod_ovf) begin
      prod_sat = shifted[SW-1] ? Q_MIN : Q_MAX;
    end else begin
      prod_sat = shifted[DATA_W-1:0];
    end
    sum     = {prod_sat[DATA_W-1], prod_sat} + {coeff_i[DATA_W-1], coeff_i};
    sum_ovf = sum[DATA_W] ^ sum[DATA_W-1];
    if (sum_ovf) begin
      sum_sat = sum[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (ctl_i.take) begin
      acc_d = '0;
      ovf_d = 1'b0;
    end else if (ctl_i.load) begin
      acc_d = coeff_i;
    end else if (ctl_i.add) begin
      acc_d = sum_sat;
      ovf_d = ovf_q | prod_ovf | sum_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.take) begin
      x_q <= point_i;
    end
    if (ctl_i.mul) begin
      prod_q <= PW'(acc_q) * PW'(x_q);
    end
  end

  assign acc_o = acc_q;
  assign ovf_o = ovf_q;

endmodule

// ----- design/peval_ctrl.sv -----
module peval_ctrl
  import peval_pkg::*;
#(
  parameter int KW = 3,
  parameter int NW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  input  logic [NW-1:0] n_i,
  output logic          in_ready_o,
  output logic [KW-1:0] k_o,
  output peval_ctl_t    ctl_o
);

  peval_state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state and term index
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_valid_i) begin
          k_d     = KW'(n_i - NW'(1));
          state_d = (n_i == '0) ? ST_FINISH : ST_LOAD;
        end
      end
      ST_LOAD, ST_ADD: begin
        if (k_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          k_d     = k_q - KW'(1);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.take = in_valid_i;
      end
      ST_LOAD:   ctl_o.load = 1'b1;
      ST_MUL:    ctl_o.mul  = 1'b1;
      ST_ADD:    ctl_o.add  = 1'b1;
      ST_FINISH: ctl_o.done = out_free_i;
      default:   ctl_o      = '0;
    endcase
  end

  assign k_o = k_q;

endmodule

// ----- design/polynomial_evaluator_unit.sv -----
// Channel   Dir  Fields (tdata / tuser, low bit first)
// s_axis    in   tdata: point[31:0]
// m_axis    out  tdata: poly_value[31:0]; tuser: overflow
// cfg       in   cfg_idx_i 0..6 coeff_0..6, 7 term_count; cfg_data_i
//
// An item is loaded with its top coefficient and then runs one Horner step per
// further used term on one shared multiplier, each a multiply state and then a
// shift/saturate/add state; n = 0 goes straight to the finish state.
// s_axis_tready is high only while the sequencer is idle; the output
// register lets the next item start while a result waits on m_axis.
// Reset is asynchronous, active low: coefficients 0, term_count 1.
`include "polynomial_evaluator_unit_assert.svh"

module polynomial_evaluator_unit
  import peval_pkg::*;
#(
  parameter int MAX_TERMS = DEFAULT_MAX_TERMS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // point[31:0]
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // poly_value[31:0]
  output logic              m_axis_tuser,   // overflow
  // register writes
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  localparam int KW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int NW = $clog2(MAX_TERMS + 1);

  peval_ctl_t               ctl;
  logic [KW-1:0]            k;
  logic [NW-1:0]            n;
  logic signed [DATA_W-1:0] coeff;
  logic signed [DATA_W-1:0] acc;
  logic                     ovf;
  logic                     out_free;

  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_ovf_q;

  peval_cfg #(
    .MAX_TERMS (MAX_TERMS),
    .KW        (KW),
    .NW        (NW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .k_i        (k),
    .coeff_o    (coeff),
    .n_o        (n)
  );

  peval_ctrl #(
    .KW (KW),
    .NW (NW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .n_i        (n),
    .in_ready_o (s_axis_tready),
    .k_o        (k),
    .ctl_o      (ctl)
  );

  peval_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .point_i (s_axis_tdata),
    .coeff_i (coeff),
    .acc_o   (acc),
    .ovf_o   (ovf)
  );

  // output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.done) begin
      out_data_q <= acc;
      out_ovf_q  <= ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  // a finished result never overwrites one still waiting
  `PEVAL_ASSERT_SAME(a_no_overwrite, ctl.done, out_free, "result overwrote pending item")
  // one item at a time: busy right after an accept
  `PEVAL_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                     "ready stayed high after accept")
  // a finished item shows up on the result port
  `PEVAL_ASSERT_NEXT(a_done_shows, ctl.done, m_axis_tvalid, "finished item not presented")

endmodule
